FILE: design/lasi_pkg.sv
// ----------------------------------------------------------------------------
// lasi_pkg
// Shared constants, payload types and controller/datapath handshake structs
// for the leveled assumption stack index unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lasi_pkg;

  localparam int STACK_DEPTH   = 256;
  localparam int INDEX_SLOTS   = 512;
  localparam int DELETED_LIMIT = 128;
  localparam int MAX_LEVEL     = 65535;

  localparam int KEY_W   = 31;
  localparam int LEVEL_W = 16;
  localparam int VALUE_W = 32;
  localparam int ENT_W   = $clog2(STACK_DEPTH);
  localparam int TOP_W   = ENT_W + 1;
  localparam int SLOT_W  = $clog2(INDEX_SLOTS);
  localparam int DEL_W   = SLOT_W + 1;

  typedef enum logic [2:0] {
    OP_ADD         = 3'd0,
    OP_OPEN        = 3'd1,
    OP_CLOSE       = 3'd2,
    OP_TERM_OF_LIT = 3'd3,
    OP_LIT_OF_TERM = 3'd4,
    OP_CLEAR       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_LEVEL  = 2'd2,
    ST_LEVEL_OVF = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY,
    SLOT_DELETED,
    SLOT_LIVE
  } slot_state_e;

  typedef enum logic [1:0] {
    ENT_TOP,
    ENT_TOP_M1,
    ENT_ZERO,
    ENT_INC
  } ent_src_e;

  typedef enum logic [1:0] {
    PK_FIND,
    PK_ADD,
    PK_REMOVE
  } probe_e;

  typedef enum logic [1:0] {
    SW_RESET,
    SW_CLEAR,
    SW_REBUILD
  } sweep_e;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DISPATCH,
    S_PROBE_START,
    S_PROBE,
    S_FETCH,
    S_POP_RD,
    S_POP_CHK,
    S_CLOSE_END,
    S_REB_LOAD,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    slot_state_e           state;
    logic [ENT_W-1:0]      ent;
    logic [KEY_W-1:0]      key;
  } slot_t;

  typedef struct packed {
    logic [2:0]            op;
    logic [KEY_W-1:0]      term_key;
    logic [KEY_W-1:0]      literal_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic signed [VALUE_W-1:0] partner_value;
  } out_item_t;

  typedef struct packed {
    logic     capture;
    logic     set_status;
    status_e  status;
    logic     set_found;
    logic     lvl_inc;
    logic     lvl_dec;
    logic     lvl_clr;
    logic     top_inc;
    logic     top_dec;
    logic     top_clr;
    logic     del_clr;
    logic     store_wr;
    logic     store_rd;
    logic     fetch;
    logic     ent_ld;
    ent_src_e ent_src;
    logic     key_ld;
    logic     key_sel;
    logic     key_store;
    logic     probe_start;
    logic     probe_adv;
    logic     slot_ins;
    logic     slot_del;
    logic     sweep_init;
    logic     sweep_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic top_full;
    logic top_zero;
    logic lvl_max;
    logic lvl_zero;
    logic lvl_match;
    logic del_over;
    logic sweep_last;
    logic cur_empty;
    logic cur_hit_key;
    logic cur_hit_ent;
    logic probe_last;
    logic reb_last;
    logic out_busy;
    logic sel;
  } stat_t;

endpackage

`default_nettype wire

FILE: design/lasi_ctrl.sv
// ----------------------------------------------------------------------------
// lasi_ctrl
// Sequencer: decodes each operation and steps the datapath through probes,
// pops, table sweeps and index rebuilds.
// ----------------------------------------------------------------------------
`default_nettype none

module lasi_ctrl import lasi_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t st_i,
  output cmd_t       cmd_o
);

  ctl_state_e state_q, state_d;
  probe_e     kind_q, kind_d;
  sweep_e     sweep_q, sweep_d;
  logic       rebuild_q, rebuild_d;
  logic       idx_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      kind_q    <= PK_FIND;
      sweep_q   <= SW_RESET;
      rebuild_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      sweep_q   <= sweep_d;
      rebuild_q <= rebuild_d;
    end
  end

  // end of the probe walk for one index
  always_comb begin
    idx_done = 1'b0;
    case (kind_q)
      PK_ADD:    idx_done = st_i.cur_hit_key || st_i.cur_empty || st_i.probe_last;
      PK_REMOVE: idx_done = st_i.cur_hit_ent || st_i.cur_empty || st_i.probe_last;
      default:   idx_done = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    sweep_d   = sweep_q;
    rebuild_d = rebuild_q;
    unique case (state_q)
      S_SWEEP: begin
        if (st_i.sweep_last) begin
          unique case (sweep_q)
            SW_RESET: state_d = S_IDLE;
            SW_CLEAR: state_d = S_DONE;
            default:  state_d = st_i.top_zero ? S_DONE : S_REB_LOAD;
          endcase
        end
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (st_i.op)
          OP_ADD: begin
            if (st_i.top_full) begin
              state_d = S_DONE;
            end else begin
              kind_d    = PK_ADD;
              rebuild_d = 1'b0;
              state_d   = S_PROBE_START;
            end
          end
          OP_CLOSE: state_d = st_i.lvl_zero ? S_DONE : S_POP_RD;
          OP_TERM_OF_LIT, OP_LIT_OF_TERM: begin
            kind_d  = PK_FIND;
            state_d = S_PROBE_START;
          end
          OP_CLEAR: begin
            sweep_d = SW_CLEAR;
            state_d = S_SWEEP;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_PROBE_START: state_d = S_PROBE;
      S_PROBE: begin
        if (kind_q == PK_FIND) begin
          if (st_i.cur_hit_key) state_d = S_FETCH;
          else if (st_i.cur_empty || st_i.probe_last) state_d = S_DONE;
        end else if (idx_done) begin
          if (!st_i.sel) state_d = S_PROBE_START;
          else if (kind_q == PK_REMOVE) state_d = S_POP_RD;
          else if (!rebuild_q || st_i.reb_last) state_d = S_DONE;
          else state_d = S_REB_LOAD;
        end
      end
      S_FETCH:  state_d = S_DONE;
      S_POP_RD: state_d = st_i.top_zero ? S_CLOSE_END : S_POP_CHK;
      S_POP_CHK: begin
        if (st_i.lvl_match) begin
          kind_d    = PK_REMOVE;
          rebuild_d = 1'b0;
          state_d   = S_PROBE_START;
        end else begin
          state_d = S_CLOSE_END;
        end
      end
      S_CLOSE_END: begin
        if (st_i.del_over) begin
          sweep_d = SW_REBUILD;
          state_d = S_SWEEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_REB_LOAD: begin
        kind_d    = PK_ADD;
        rebuild_d = 1'b1;
        state_d   = S_PROBE_START;
      end
      S_DONE: begin
        if (!st_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (st_i.sweep_last) begin
          unique case (sweep_q)
            SW_RESET: ;
            SW_CLEAR: begin
              cmd_o.top_clr = 1'b1;
              cmd_o.lvl_clr = 1'b1;
              cmd_o.del_clr = 1'b1;
            end
            default: begin
              cmd_o.del_clr = 1'b1;
              if (!st_i.top_zero) begin
                cmd_o.ent_ld   = 1'b1;
                cmd_o.ent_src  = ENT_ZERO;
                cmd_o.store_rd = 1'b1;
              end
            end
          endcase
        end
      end
      S_IDLE: cmd_o.capture = in_valid_i;
      S_DISPATCH: begin
        unique case (st_i.op)
          OP_ADD: begin
            if (st_i.top_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.store_wr = 1'b1;
              cmd_o.ent_ld   = 1'b1;
              cmd_o.ent_src  = ENT_TOP;
              cmd_o.key_ld   = 1'b1;
            end
          end
          OP_OPEN: begin
            if (st_i.lvl_max) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_LEVEL_OVF;
            end else begin
              cmd_o.lvl_inc = 1'b1;
            end
          end
          OP_CLOSE: begin
            if (st_i.lvl_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NO_LEVEL;
            end
          end
          OP_TERM_OF_LIT: cmd_o.key_ld = 1'b1;
          OP_LIT_OF_TERM: begin
            cmd_o.key_ld  = 1'b1;
            cmd_o.key_sel = 1'b1;
          end
          OP_CLEAR: cmd_o.sweep_init = 1'b1;
          default: ;
        endcase
      end
      S_PROBE_START: cmd_o.probe_start = 1'b1;
      S_PROBE: begin
        unique case (kind_q)
          PK_FIND: begin
            if (st_i.cur_hit_key) begin
              cmd_o.store_rd = 1'b1;
              cmd_o.fetch    = 1'b1;
            end else if (!st_i.cur_empty && !st_i.probe_last) begin
              cmd_o.probe_adv = 1'b1;
            end
          end
          PK_ADD: begin
            if (!idx_done) cmd_o.probe_adv = 1'b1;
            else if (!st_i.cur_hit_key) cmd_o.slot_ins = 1'b1;
          end
          default: begin
            if (st_i.cur_hit_ent) cmd_o.slot_del = 1'b1;
            else if (!idx_done) cmd_o.probe_adv = 1'b1;
          end
        endcase
        if (kind_q != PK_FIND && idx_done) begin
          if (!st_i.sel) begin
            // same entry, now the term index
            cmd_o.key_ld    = 1'b1;
            cmd_o.key_sel   = 1'b1;
            cmd_o.key_store = rebuild_q || (kind_q == PK_REMOVE);
          end else if (kind_q == PK_ADD && !rebuild_q) begin
            cmd_o.top_inc = 1'b1;
          end else if (kind_q == PK_ADD && !st_i.reb_last) begin
            cmd_o.ent_ld   = 1'b1;
            cmd_o.ent_src  = ENT_INC;
            cmd_o.store_rd = 1'b1;
          end
        end
      end
      S_FETCH: cmd_o.set_found = 1'b1;
      S_POP_RD: begin
        if (!st_i.top_zero) begin
          cmd_o.ent_ld   = 1'b1;
          cmd_o.ent_src  = ENT_TOP_M1;
          cmd_o.store_rd = 1'b1;
        end
      end
      S_POP_CHK: begin
        if (st_i.lvl_match) begin
          cmd_o.top_dec   = 1'b1;
          cmd_o.key_ld    = 1'b1;
          cmd_o.key_store = 1'b1;
        end
      end
      S_CLOSE_END: begin
        cmd_o.lvl_dec    = 1'b1;
        cmd_o.sweep_init = st_i.del_over;
      end
      S_REB_LOAD: begin
        cmd_o.key_ld    = 1'b1;
        cmd_o.key_store = 1'b1;
      end
      S_DONE: cmd_o.out_load = !st_i.out_busy;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

FILE: design/lasi_dpath.sv
// ----------------------------------------------------------------------------
// lasi_dpath
// Entry stores, the two slot tables, probe registers, counters and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lasi_dpath import lasi_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cmd_t     cmd_i,
  output stat_t         st_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o
);

  logic [2:0]         op_q;
  logic [KEY_W-1:0]   term_q, lit_q;
  logic [TOP_W-1:0]   top_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic [DEL_W-1:0]   ldel_q, tdel_q;
  logic               sel_q;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [ENT_W-1:0]   ent_q, ent_d;
  logic [SLOT_W-1:0]  idx_q, cnt_q, free_q;
  logic               free_vld_q, free_del_q;
  logic [1:0]         status_q;
  logic               found_q;
  logic [VALUE_W-1:0] partner_q;
  out_item_t          out_q;
  logic               out_valid_q;

  logic [KEY_W-1:0]   term_mem [STACK_DEPTH];
  logic [KEY_W-1:0]   lit_mem  [STACK_DEPTH];
  logic [LEVEL_W-1:0] lvl_mem  [STACK_DEPTH];
  logic [KEY_W-1:0]   t_rd_q, l_rd_q;
  logic [LEVEL_W-1:0] v_rd_q;

  slot_t              lslot_mem [INDEX_SLOTS];
  slot_t              tslot_mem [INDEX_SLOTS];
  slot_t              lslot_rd_q, tslot_rd_q;

  slot_t              cur;
  logic               cur_live;
  logic [ENT_W-1:0]   store_raddr;
  logic [SLOT_W-1:0]  slot_raddr, wr_addr, ins_addr;
  logic               ins_ok, ins_was_del, wr_any;
  slot_t              wr_data;

  assign cur      = sel_q ? tslot_rd_q : lslot_rd_q;
  assign cur_live = (cur.state == SLOT_LIVE);

  always_comb begin
    unique case (cmd_i.ent_src)
      ENT_TOP:    ent_d = top_q[ENT_W-1:0];
      ENT_TOP_M1: ent_d = ENT_W'(top_q - TOP_W'(1));
      ENT_ZERO:   ent_d = '0;
      default:    ent_d = ent_q + ENT_W'(1);
    endcase
  end

  always_comb begin
    if (cmd_i.key_store) key_d = cmd_i.key_sel ? t_rd_q : l_rd_q;
    else                 key_d = cmd_i.key_sel ? term_q : lit_q;
  end

  assign store_raddr = cmd_i.fetch ? cur.ent : ent_d;
  assign slot_raddr  = cmd_i.probe_start ? key_q[SLOT_W-1:0] : idx_q + SLOT_W'(1);

  // insert goes to the first free slot seen on the walk, or the current one
  assign ins_ok      = cmd_i.slot_ins && (free_vld_q || !cur_live);
  assign ins_addr    = free_vld_q ? free_q : idx_q;
  assign ins_was_del = free_vld_q ? free_del_q : (cur.state == SLOT_DELETED);
  assign wr_any      = ins_ok || cmd_i.slot_del;

  always_comb begin
    if (cmd_i.sweep_step) begin
      wr_addr = idx_q;
      wr_data = '{state: SLOT_EMPTY, ent: '0, key: '0};
    end else if (ins_ok) begin
      wr_addr = ins_addr;
      wr_data = '{state: SLOT_LIVE, ent: ent_q, key: key_q};
    end else begin
      wr_addr = idx_q;
      wr_data = '{state: SLOT_DELETED, ent: ent_q, key: key_q};
    end
  end

  // entry stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      term_mem[top_q[ENT_W-1:0]] <= term_q;
      lit_mem[top_q[ENT_W-1:0]]  <= lit_q;
      lvl_mem[top_q[ENT_W-1:0]]  <= lvl_q;
    end
    if (cmd_i.store_rd) begin
      t_rd_q <= term_mem[store_raddr];
      l_rd_q <= lit_mem[store_raddr];
      v_rd_q <= lvl_mem[store_raddr];
    end
  end

  // slot tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step || (!sel_q && wr_any)) lslot_mem[wr_addr] <= wr_data;
    if (cmd_i.sweep_step || (sel_q && wr_any))  tslot_mem[wr_addr] <= wr_data;
    lslot_rd_q <= lslot_mem[slot_raddr];
    tslot_rd_q <= tslot_mem[slot_raddr];
  end

  // item, key and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= in_item_i.op;
      term_q    <= in_item_i.term_key;
      lit_q     <= in_item_i.literal_key;
      status_q  <= ST_OK;
      found_q   <= 1'b0;
      partner_q <= '1;
    end
    if (cmd_i.set_status) status_q <= cmd_i.status;
    if (cmd_i.set_found) begin
      found_q   <= 1'b1;
      partner_q <= {1'b0, (sel_q ? l_rd_q : t_rd_q)};
    end
    if (cmd_i.key_ld) begin
      key_q <= key_d;
      sel_q <= cmd_i.key_sel;
    end
    if (cmd_i.ent_ld) ent_q <= ent_d;
    if (cmd_i.probe_adv && !free_vld_q && !cur_live) begin
      free_q     <= idx_q;
      free_del_q <= (cur.state == SLOT_DELETED);
    end
    if (cmd_i.out_load) out_q <= '{status: status_q, found: found_q, partner_value: partner_q};
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      lvl_q       <= '0;
      ldel_q      <= '0;
      tdel_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      free_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.top_clr)      top_q <= '0;
      else if (cmd_i.top_inc) top_q <= top_q + TOP_W'(1);
      else if (cmd_i.top_dec) top_q <= top_q - TOP_W'(1);

      if (cmd_i.lvl_clr)      lvl_q <= '0;
      else if (cmd_i.lvl_inc) lvl_q <= lvl_q + LEVEL_W'(1);
      else if (cmd_i.lvl_dec) lvl_q <= lvl_q - LEVEL_W'(1);

      if (cmd_i.del_clr) begin
        ldel_q <= '0;
        tdel_q <= '0;
      end else if (ins_ok && ins_was_del) begin
        if (!sel_q && ldel_q != '0) ldel_q <= ldel_q - DEL_W'(1);
        if (sel_q && tdel_q != '0)  tdel_q <= tdel_q - DEL_W'(1);
      end else if (cmd_i.slot_del) begin
        if (!sel_q) ldel_q <= ldel_q + DEL_W'(1);
        else        tdel_q <= tdel_q + DEL_W'(1);
      end

      if (cmd_i.sweep_init) begin
        idx_q <= '0;
      end else if (cmd_i.sweep_step) begin
        idx_q <= idx_q + SLOT_W'(1);
      end else if (cmd_i.probe_start) begin
        idx_q      <= key_q[SLOT_W-1:0];
        cnt_q      <= '0;
        free_vld_q <= 1'b0;
      end else if (cmd_i.probe_adv) begin
        idx_q <= idx_q + SLOT_W'(1);
        cnt_q <= cnt_q + SLOT_W'(1);
        if (!cur_live) free_vld_q <= 1'b1;
      end

      if (cmd_i.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    st_o.op          = op_e'(op_q);
    st_o.top_full    = (top_q == TOP_W'(STACK_DEPTH));
    st_o.top_zero    = (top_q == '0);
    st_o.lvl_max     = (lvl_q == LEVEL_W'(MAX_LEVEL));
    st_o.lvl_zero    = (lvl_q == '0);
    st_o.lvl_match   = (v_rd_q == lvl_q);
    st_o.del_over    = (ldel_q >= DEL_W'(DELETED_LIMIT)) || (tdel_q >= DEL_W'(DELETED_LIMIT));
    st_o.sweep_last  = (idx_q == SLOT_W'(INDEX_SLOTS - 1));
    st_o.cur_empty   = (cur.state == SLOT_EMPTY);
    st_o.cur_hit_key = cur_live && (cur.key == key_q);
    st_o.cur_hit_ent = cur_live && (cur.ent == ent_q);
    st_o.probe_last  = (cnt_q == SLOT_W'(INDEX_SLOTS - 1));
    st_o.reb_last    = ((TOP_W'(ent_q) + TOP_W'(1)) == top_q);
    st_o.out_busy    = out_valid_q && !out_ready_i;
    st_o.sel         = sel_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TOP_W'(STACK_DEPTH))
    else $error("stack top past depth");

  a_one_slot_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slot_ins |-> !cmd_i.slot_del && !cmd_i.sweep_step)
    else $error("conflicting slot table writes");

  a_partner_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (out_q.found ? !out_q.partner_value[VALUE_W-1]
                                    : (out_q.partner_value == '1)))
    else $error("partner value inconsistent with found flag");

endmodule

`default_nettype wire

FILE: design/leveled_assumption_stack_index_unit.sv
// ----------------------------------------------------------------------------
// leveled_assumption_stack_index_unit
// Stack of (term, literal, level) entries with hashed literal and term
// indexes, linear probing and deletion marks, one result per operation.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Open level, illegal codes and the
// error cases of add and close need no probe walk. A lookup probes one
// index from its home slot, and on a hit reads the entry store. An add
// probes the literal index and then the term index. Close pops entries of
// the top level, removing each from both indexes; when either index has
// collected DELETED_LIMIT deletion marks both slot tables are swept and
// every live entry is reinserted. Clear is a sweep of all INDEX_SLOTS
// slots of both slot tables. After reset the slot tables are swept with
// in_ready_o low. Each slot table has a single read port: one slot per
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module leveled_assumption_stack_index_unit import lasi_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t st;

  // sequencer: decode, probe walks, pops, sweeps and rebuilds
  lasi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // stores, slot tables and the result register; the result register lets
  // the next transfer in start while a result waits on out_ready_i
  lasi_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_leveled_assumption_stack_index_unit.sv
// ----------------------------------------------------------------------------
// tb_leveled_assumption_stack_index_unit
// Random and directed stimulus against a behavioral predictor of the
// leveled stack, the literal and term indexes and their deletion marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_leveled_assumption_stack_index_unit;
  import lasi_pkg::*;

  localparam int IDLE_LIMIT = 2000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  leveled_assumption_stack_index_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state, slot value -1 empty, -2 deleted, else entry index
  logic [KEY_W-1:0]   pm_term [STACK_DEPTH];
  logic [KEY_W-1:0]   pm_lit  [STACK_DEPTH];
  logic [LEVEL_W-1:0] pm_lvl  [STACK_DEPTH];
  int pm_top, pm_level, lit_del, term_del;
  int lit_slot [INDEX_SLOTS];
  int term_slot [INDEX_SLOTS];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int  errors = 0;
  bit  no_idle = 1'b0;
  bit  hold_send = 1'b0;
  int  n_lookup_hits = 0, n_rebuilds = 0, n_results = 0;

  function automatic logic [KEY_W-1:0] key_of(bit by_lit, int j);
    return by_lit ? pm_lit[j] : pm_term[j];
  endfunction

  function automatic int index_find(bit by_lit, logic [KEY_W-1:0] key);
    int i, j;
    i = key % INDEX_SLOTS;
    for (int n = 0; n < INDEX_SLOTS; n++) begin
      j = by_lit ? lit_slot[i] : term_slot[i];
      if (j == -1) return -1;
      if (j >= 0 && key_of(by_lit, j) == key) return j;
      i = (i + 1) % INDEX_SLOTS;
    end
    return -1;
  endfunction

  task automatic index_add(bit by_lit, logic [KEY_W-1:0] key, int x);
    int i, j, free_at;
    i = key % INDEX_SLOTS;
    free_at = -1;
    for (int n = 0; n < INDEX_SLOTS; n++) begin
      j = by_lit ? lit_slot[i] : term_slot[i];
      if (j < 0) begin
        if (free_at < 0) free_at = i;
        if (j == -1) break;
      end else if (key_of(by_lit, j) == key) begin
        return;
      end
      i = (i + 1) % INDEX_SLOTS;
    end
    if (free_at < 0) return;
    if (by_lit) begin
      if (lit_slot[free_at] == -2 && lit_del > 0) lit_del--;
      lit_slot[free_at] = x;
    end else begin
      if (term_slot[free_at] == -2 && term_del > 0) term_del--;
      term_slot[free_at] = x;
    end
  endtask

  task automatic index_remove(bit by_lit, logic [KEY_W-1:0] key, int x);
    int i, j;
    i = key % INDEX_SLOTS;
    for (int n = 0; n < INDEX_SLOTS; n++) begin
      j = by_lit ? lit_slot[i] : term_slot[i];
      if (j == x) begin
        if (by_lit) begin lit_slot[i] = -2; lit_del++; end
        else begin term_slot[i] = -2; term_del++; end
        return;
      end
      if (j == -1) return;
      i = (i + 1) % INDEX_SLOTS;
    end
  endtask

  task automatic index_rebuild(bit by_lit);
    int old_slots [INDEX_SLOTS];
    int i, x;
    for (int s = 0; s < INDEX_SLOTS; s++) begin
      old_slots[s] = by_lit ? lit_slot[s] : term_slot[s];
      if (by_lit) lit_slot[s] = -1; else term_slot[s] = -1;
    end
    for (int s = 0; s < INDEX_SLOTS; s++) begin
      x = old_slots[s];
      if (x < 0) continue;
      i = key_of(by_lit, x) % INDEX_SLOTS;
      for (int n = 0; n < INDEX_SLOTS; n++) begin
        if ((by_lit ? lit_slot[i] : term_slot[i]) < 0) begin
          if (by_lit) lit_slot[i] = x; else term_slot[i] = x;
          break;
        end
        i = (i + 1) % INDEX_SLOTS;
      end
    end
    if (by_lit) lit_del = 0; else term_del = 0;
    n_rebuilds++;
  endtask

  task automatic clear_stack();
    pm_top = 0; pm_level = 0; lit_del = 0; term_del = 0;
    for (int s = 0; s < INDEX_SLOTS; s++) begin
      lit_slot[s] = -1; term_slot[s] = -1;
    end
  endtask

  // apply one operation to the model and queue its result
  task automatic predict_stack_op(in_item_t it);
    out_item_t r;
    int j;
    r.status = ST_OK; r.found = 1'b0; r.partner_value = -32'sd1;
    case (it.op)
      OP_ADD: begin
        if (pm_top >= STACK_DEPTH) r.status = ST_FULL;
        else begin
          pm_term[pm_top] = it.term_key;
          pm_lit[pm_top]  = it.literal_key;
          pm_lvl[pm_top]  = LEVEL_W'(pm_level);
          index_add(1'b1, it.literal_key, pm_top);
          index_add(1'b0, it.term_key, pm_top);
          pm_top++;
        end
      end
      OP_OPEN: begin
        if (pm_level >= MAX_LEVEL) r.status = ST_LEVEL_OVF;
        else pm_level++;
      end
      OP_CLOSE: begin
        if (pm_level == 0) r.status = ST_NO_LEVEL;
        else begin
          while (pm_top > 0 && pm_lvl[pm_top-1] == pm_level) begin
            pm_top--;
            index_remove(1'b1, pm_lit[pm_top], pm_top);
            index_remove(1'b0, pm_term[pm_top], pm_top);
          end
          pm_level--;
          if (lit_del > 0 && lit_del >= DELETED_LIMIT) index_rebuild(1'b1);
          if (term_del > 0 && term_del >= DELETED_LIMIT) index_rebuild(1'b0);
        end
      end
      OP_TERM_OF_LIT: begin
        j = index_find(1'b1, it.literal_key);
        if (j >= 0) begin r.found = 1'b1; r.partner_value = {1'b0, pm_term[j]}; end
      end
      OP_LIT_OF_TERM: begin
        j = index_find(1'b0, it.term_key);
        if (j >= 0) begin r.found = 1'b1; r.partner_value = {1'b0, pm_lit[j]}; end
      end
      OP_CLEAR: clear_stack();
      default: ;
    endcase
    if (r.found) n_lookup_hits++;
    expected_results.push_back(r);
  endtask

  function automatic in_item_t mk(logic [2:0] op, logic [KEY_W-1:0] t,
                                  logic [KEY_W-1:0] l);
    in_item_t it;
    it.op = op; it.term_key = t; it.literal_key = l;
    return it;
  endfunction

  // small key pool so lookups hit and probes collide
  function automatic logic [KEY_W-1:0] pool_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return KEY_W'($urandom_range(0, 23) * INDEX_SLOTS + $urandom_range(0, 3));
    if (sel < 8) return KEY_W'($urandom_range(0, 40));
    return KEY_W'($urandom());
  endfunction

  // driver: one transfer per handshake, valid held until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_stack_op(in_item_i);
        void'(pending_items.pop_front());
      end
      if ((!in_valid_i || in_ready_o) ) begin
        if (pending_items.size() > (in_valid_i && in_ready_o ? 0 : 0) &&
            !hold_send && (no_idle || $urandom_range(0, 99) >= 34)) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_items[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result with no prediction waiting: %h", out_item_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_item_o.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_item_o.status);
            errors++;
          end
          if (out_item_o.found !== e.found) begin
            $error("found expected %0d actual %0d", e.found, out_item_o.found);
            errors++;
          end
          if (out_item_o.partner_value !== e.partner_value) begin
            $error("partner_value expected %0d actual %0d",
                   e.partner_value, out_item_o.partner_value);
            errors++;
          end
        end
      end
      out_ready_i <= no_idle || ($urandom_range(0, 99) >= 34);
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else if (rst_ni && (pending_items.size() > 0 || expected_results.size() > 0)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("leveled_assumption_stack_index_unit verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int kind;
    logic [KEY_W-1:0] k;
    clear_stack();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: extremes, each op, error cases
    pending_items.push_back(mk(OP_CLOSE, 0, 0));                 // close at level zero
    pending_items.push_back(mk(OP_TERM_OF_LIT, 0, 0));           // miss on empty index
    pending_items.push_back(mk(OP_ADD, '1, '1));
    pending_items.push_back(mk(OP_ADD, 0, 0));
    pending_items.push_back(mk(OP_ADD, 31'd512, 31'd512));       // collides with zero
    pending_items.push_back(mk(OP_TERM_OF_LIT, 0, '1));
    pending_items.push_back(mk(OP_LIT_OF_TERM, '1, 0));
    pending_items.push_back(mk(OP_LIT_OF_TERM, 31'd512, 0));
    pending_items.push_back(mk(OP_OPEN, 0, 0));
    pending_items.push_back(mk(OP_ADD, 0, 31'h2AAAAAAA));         // duplicate term
    pending_items.push_back(mk(OP_ADD, 31'h55555555, 0));         // duplicate literal
    pending_items.push_back(mk(OP_LIT_OF_TERM, 0, 0));
    pending_items.push_back(mk(OP_CLOSE, 0, 0));
    pending_items.push_back(mk(OP_TERM_OF_LIT, 0, 31'h2AAAAAAA));
    pending_items.push_back(mk(3'd6, '1, '1));                    // unused codes
    pending_items.push_back(mk(3'd7, 0, 0));
    pending_items.push_back(mk(OP_CLEAR, 0, 0));
    pending_items.push_back(mk(OP_LIT_OF_TERM, '1, '1));
    wait_drained();

    // fill the stack past full, then close it all to force rebuilds
    no_idle = 1'b1;
    pending_items.push_back(mk(OP_OPEN, 0, 0));
    for (int i = 0; i < STACK_DEPTH + 2; i++)
      pending_items.push_back(mk(OP_ADD, pool_key(), pool_key()));
    for (int i = 0; i < 4; i++)
      pending_items.push_back(mk(OP_TERM_OF_LIT, 0, pool_key()));
    pending_items.push_back(mk(OP_CLOSE, 0, 0));
    pending_items.push_back(mk(OP_LIT_OF_TERM, pool_key(), 0));
    wait_drained();
    no_idle = 1'b0;

    // random leveled sequences
    for (int n = 0; n < 460; n++) begin
      kind = $urandom_range(0, 99);
      k = pool_key();
      if (n == 230) begin
        wait_drained();     // sender holds off until all results are back
        hold_send = 1'b1;
        repeat (20) @(posedge clk_i);
        hold_send = 1'b0;
      end
      if (kind < 40) pending_items.push_back(mk(OP_ADD, k, pool_key()));
      else if (kind < 50)
        pending_items.push_back(mk(OP_OPEN, KEY_W'($urandom()), KEY_W'($urandom())));
      else if (kind < 58)
        pending_items.push_back(mk(OP_CLOSE, KEY_W'($urandom()), KEY_W'($urandom())));
      else if (kind < 77)
        pending_items.push_back(mk(OP_TERM_OF_LIT, KEY_W'($urandom()), k));
      else if (kind < 96)
        pending_items.push_back(mk(OP_LIT_OF_TERM, k, KEY_W'($urandom())));
      else if (kind < 98)
        pending_items.push_back(mk(OP_CLEAR, KEY_W'($urandom()), KEY_W'($urandom())));
      else
        pending_items.push_back(mk(3'($urandom_range(6, 7)), KEY_W'($urandom()),
                                   KEY_W'($urandom())));
    end
    wait_drained();
    repeat (4 * INDEX_SLOTS) @(posedge clk_i);

    $display("run covered %0d results, %0d lookup hits, %0d index rebuilds",
             n_results, n_lookup_hits, n_rebuilds);
    $display("stack fill, close of a full level, clear, and duplicate keys included");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("leveled_assumption_stack_index_unit verification clean");
    end else begin
      $display("leveled_assumption_stack_index_unit verification failed");
    end
    $finish;
  end

endmodule
